// ===== src/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the road segment projector.
// ----------------------------------------------------------------------------
package rsp_pkg;

    // Fractional bits of the perspective scale.
    localparam int SCALE_FRAC_BITS = 24;

    // Width of world coordinates and of a projection magnitude.
    localparam int WORLD_W   = 24;
    localparam int DIV_CNT_W = $clog2(SCALE_FRAC_BITS + 1);
    localparam int PROD_W    = SCALE_FRAC_BITS + WORLD_W;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_DEPTH_FACTOR       = 4'd0,
        REG_HALF_SCREEN_WIDTH  = 4'd1,
        REG_HALF_SCREEN_HEIGHT = 4'd2,
        REG_ROAD_HALF_WIDTH    = 4'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Projection terms handled by the shared multiplier.
    typedef enum logic [1:0] {
        TERM_X = 2'd0,
        TERM_Y = 2'd1,
        TERM_W = 2'd2
    } t_term;

    // Multiplier passes within one term.
    typedef enum logic [1:0] {
        PH_SCALE = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_FINAL = 2'd3
    } t_phase;

endpackage

// ===== src/road_segment_projector.sv =====
// ----------------------------------------------------------------------------
// road_segment_projector
// Projects one road segment per transaction to screen column, row and half
// width, tracking curve accumulators and the topmost drawn row of a frame.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      i_in_valid / o_in_stall  segment and camera fields
//  out      output     o_out_valid / i_out_stall projections, visible, stripe
//  cfg      input      i_cfg_valid / o_cfg_ready register index and data
//
// A segment in front of the camera is accepted, prepared, passed through the
// bit-serial divider and through the passes of the shared multiplier (four
// per projected term), then delivered. A segment at or behind the camera
// skips the divider and the multiplier.
// Reset is synchronous and active low and restores the register defaults.
// A stalled result holds the sequencer in its delivery state; a new segment
// may be accepted while an earlier result still waits.
// ----------------------------------------------------------------------------
module road_segment_projector (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Segment input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_frame_start,
    input  logic [15:0]        i_segment_number,
    input  logic [23:0]        i_segment_depth,
    input  logic signed [23:0] i_segment_height,
    input  logic signed [15:0] i_segment_curve,
    input  logic signed [23:0] i_camera_x,
    input  logic signed [23:0] i_camera_height,
    input  logic [23:0]        i_camera_depth,
    // Result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic [15:0]        o_screen_w,
    output logic signed [15:0] o_prev_x,
    output logic signed [15:0] o_prev_y,
    output logic [15:0]        o_prev_w,
    output logic               o_visible,
    output logic               o_stripe_band,
    // Configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int SFB = rsp_pkg::SCALE_FRAC_BITS;
    localparam int WW  = rsp_pkg::WORLD_W;
    localparam int PW  = rsp_pkg::PROD_W;

    // Configuration registers
    logic [15:0]        r_depth_factor;
    logic [11:0]        r_hsw;
    logic [11:0]        r_hsh;
    logic [15:0]        r_rhw;

    // Frame state
    rsp_pkg::t_state    r_state;
    rsp_pkg::t_state    n_state;
    logic [31:0]        r_offset;
    logic [23:0]        r_slope;
    logic signed [15:0] r_top;
    logic [15:0]        r_last_x;
    logic [15:0]        r_last_y;
    logic [15:0]        r_last_w;

    // Captured segment
    logic               r_fs;
    logic [15:0]        r_segnum;
    logic [23:0]        r_zd;
    logic [23:0]        r_camz;
    logic [24:0]        r_camx;
    logic [24:0]        r_offint;
    logic [24:0]        r_dy;

    // Prepared operands
    logic [WW-1:0]      r_mag_x;
    logic               r_neg_x;
    logic [WW-1:0]      r_mag_y;
    logic               r_neg_y;
    logic               r_dpos;
    logic               r_stripe;

    // Multiplier sequencing
    rsp_pkg::t_term     r_term;
    rsp_pkg::t_phase    r_ph;
    logic [PW-1:0]      r_prod;
    logic [WW-1:0]      r_phi;
    logic [11:0]        r_lo;
    logic signed [15:0] r_sx;
    logic signed [15:0] r_sy;
    logic [15:0]        r_sw;

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_o_sx;
    logic signed [15:0] r_o_sy;
    logic [15:0]        r_o_sw;
    logic signed [15:0] r_o_px;
    logic signed [15:0] r_o_py;
    logic [15:0]        r_o_pw;
    logic               r_o_vis;
    logic               r_o_stripe;

    // Combinational helpers
    logic               in_accept;
    logic [31:0]        off_eff;
    logic [23:0]        slope_eff;
    logic [32:0]        off_adj;
    logic [24:0]        cx;
    logic [24:0]        zdiff;
    logic               dpos;
    logic [31:0]        third;
    logic               div_start;
    logic               div_done;
    logic [SFB-1:0]     div_quot;
    logic [SFB-1:0]     div_num;
    logic [11:0]        term_k;
    logic [WW-1:0]      term_mag;
    logic               term_neg;
    logic [SFB-1:0]     mul_a;
    logic [WW-1:0]      mul_b;
    logic [PW-1:0]      mul_p;
    logic [36:0]        term_m;
    logic signed [37:0] term_t;
    logic signed [38:0] term_v;
    logic               out_load;
    logic signed [15:0] fin_sx;
    logic signed [15:0] fin_sy;
    logic [15:0]        fin_sw;
    logic               fin_vis;

    function automatic logic signed [15:0] sat_s16(input logic signed [38:0] v);
        logic signed [15:0] res;
        if (v > 39'sd32767) begin
            res = 16'sh7FFF;
        end else if (v < -39'sd32768) begin
            res = -16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != rsp_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Curve accumulators as seen by the item, cleared at a frame start.
    // The integer part of the offset is truncated toward zero.
    always_comb begin
        off_eff   = i_frame_start ? 32'd0 : r_offset;
        slope_eff = i_frame_start ? 24'd0 : r_slope;
        off_adj   = {off_eff[31], off_eff} + (off_eff[31] ? 33'd255 : 33'd0);
    end

    // Preparation: lateral offset, depth difference and stripe band.
    always_comb begin
        cx    = r_camx - r_offint;
        zdiff = {1'b0, r_zd} - {1'b0, r_camz};
        dpos  = !zdiff[24] && (zdiff[23:0] != 24'd0);
        // Divide by three through the reciprocal 0xAAAB over 2^17.
        third = 32'(r_segnum) * 32'd43691;
    end

    assign div_start = (r_state == rsp_pkg::S_PREP) && dpos;
    assign div_num   = SFB'(r_depth_factor) << (SFB - 16);

    rsp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (zdiff[WW-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Operand selection for the current term.
    always_comb begin
        unique case (r_term)
            rsp_pkg::TERM_X: begin
                term_k   = r_hsw;
                term_mag = r_mag_x;
                term_neg = r_neg_x;
            end
            rsp_pkg::TERM_Y: begin
                term_k   = r_hsh;
                term_mag = r_mag_y;
                term_neg = r_neg_y;
            end
            default: begin
                term_k   = r_hsw;
                term_mag = WW'(r_rhw);
                term_neg = 1'b0;
            end
        endcase
    end

    // Shared multiplier: scale times magnitude, then the low and high halves
    // of that product times the screen half size.
    always_comb begin
        unique case (r_ph)
            rsp_pkg::PH_SCALE: begin
                mul_a = div_quot;
                mul_b = term_mag;
            end
            rsp_pkg::PH_LOW: begin
                mul_a = r_prod[SFB-1:0];
                mul_b = WW'(term_k);
            end
            rsp_pkg::PH_HIGH: begin
                mul_a = SFB'(term_k);
                mul_b = r_phi;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    // Final pass: combine halves, apply the sign and saturate.
    always_comb begin
        term_m = {1'b0, r_prod[35:0]} + 37'(r_lo);
        term_t = term_neg ? -$signed({1'b0, term_m}) : $signed({1'b0, term_m});
        term_v = $signed({27'd0, term_k}) - 39'(term_t);
    end

    // Result assembly at delivery.
    always_comb begin
        fin_sx  = r_dpos ? r_sx : 16'sd0;
        fin_sy  = r_dpos ? r_sy : 16'sd0;
        fin_sw  = r_dpos ? r_sw : 16'd0;
        fin_vis = r_dpos && (r_sy < r_top);
        out_load = (r_state == rsp_pkg::S_OUT) && (!r_out_valid || !i_out_stall);
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsp_pkg::S_IDLE: if (in_accept) n_state = rsp_pkg::S_PREP;
            rsp_pkg::S_PREP: n_state = dpos ? rsp_pkg::S_DIV : rsp_pkg::S_OUT;
            rsp_pkg::S_DIV:  if (div_done) n_state = rsp_pkg::S_MUL;
            rsp_pkg::S_MUL: begin
                if (r_term == rsp_pkg::TERM_W && r_ph == rsp_pkg::PH_FINAL) begin
                    n_state = rsp_pkg::S_OUT;
                end
            end
            rsp_pkg::S_OUT:  if (out_load) n_state = rsp_pkg::S_IDLE;
            default:         n_state = rsp_pkg::S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_factor <= 16'd55050;
            r_hsw          <= 12'd640;
            r_hsh          <= 12'd360;
            r_rhw          <= 16'd2000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rsp_pkg::REG_DEPTH_FACTOR:       r_depth_factor <= i_cfg_data;
                rsp_pkg::REG_HALF_SCREEN_WIDTH:  r_hsw <= i_cfg_data[11:0];
                rsp_pkg::REG_HALF_SCREEN_HEIGHT: r_hsh <= i_cfg_data[11:0];
                rsp_pkg::REG_ROAD_HALF_WIDTH:    r_rhw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state, accumulators and the topmost row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rsp_pkg::S_IDLE;
            r_offset <= 32'd0;
            r_slope  <= 24'd0;
            r_top    <= 16'sd720;
            r_last_x <= 16'd0;
            r_last_y <= 16'd0;
            r_last_w <= 16'd0;
            r_term   <= rsp_pkg::TERM_X;
            r_ph     <= rsp_pkg::PH_SCALE;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_offset <= off_eff + {{8{slope_eff[23]}}, slope_eff};
                r_slope  <= slope_eff + {{8{i_segment_curve[15]}}, i_segment_curve};
                if (i_frame_start) begin
                    r_top <= $signed({3'b000, r_hsh, 1'b0});
                end
            end
            if (r_state == rsp_pkg::S_DIV) begin
                r_term <= rsp_pkg::TERM_X;
                r_ph   <= rsp_pkg::PH_SCALE;
            end else if (r_state == rsp_pkg::S_MUL) begin
                r_ph <= rsp_pkg::t_phase'(r_ph + 2'd1);
                if (r_ph == rsp_pkg::PH_FINAL) begin
                    r_term <= rsp_pkg::t_term'(r_term + 2'd1);
                end
            end
            if (out_load) begin
                if (fin_vis) begin
                    r_top <= r_sy;
                end
                if (r_dpos) begin
                    r_last_x <= r_sx;
                    r_last_y <= r_sy;
                    r_last_w <= r_sw;
                end
            end
        end
    end

    // Segment capture, preparation and the multiplier datapath.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fs     <= i_frame_start;
            r_segnum <= i_segment_number;
            r_zd     <= i_segment_depth;
            r_camz   <= i_camera_depth;
            r_camx   <= {i_camera_x[23], i_camera_x};
            r_offint <= off_adj[32:8];
            r_dy     <= {i_segment_height[23], i_segment_height}
                        - {i_camera_height[23], i_camera_height};
        end
        if (r_state == rsp_pkg::S_PREP) begin
            r_neg_x  <= cx[24];
            r_mag_x  <= cx[24] ? WW'(-cx) : cx[WW-1:0];
            r_neg_y  <= r_dy[24];
            r_mag_y  <= r_dy[24] ? WW'(-r_dy) : r_dy[WW-1:0];
            r_dpos   <= dpos;
            r_stripe <= third[17];
        end
        if (r_state == rsp_pkg::S_MUL) begin
            r_prod <= mul_p;
            if (r_ph == rsp_pkg::PH_LOW) begin
                r_phi <= r_prod[PW-1:SFB];
            end
            if (r_ph == rsp_pkg::PH_HIGH) begin
                r_lo <= r_prod[SFB+11:SFB];
            end
            if (r_ph == rsp_pkg::PH_FINAL) begin
                unique case (r_term)
                    rsp_pkg::TERM_X: r_sx <= sat_s16(term_v);
                    rsp_pkg::TERM_Y: r_sy <= sat_s16(term_v);
                    default:         r_sw <= (term_m > 37'd65535) ? 16'hFFFF : term_m[15:0];
                endcase
            end
        end
    end

    // Output register: a result stays until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_sx     <= fin_sx;
            r_o_sy     <= fin_sy;
            r_o_sw     <= fin_sw;
            r_o_px     <= r_fs ? fin_sx : r_last_x;
            r_o_py     <= r_fs ? fin_sy : r_last_y;
            r_o_pw     <= r_fs ? fin_sw : r_last_w;
            r_o_vis    <= fin_vis;
            r_o_stripe <= r_stripe;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_screen_x    = r_o_sx;
    assign o_screen_y    = r_o_sy;
    assign o_screen_w    = r_o_sw;
    assign o_prev_x      = r_o_px;
    assign o_prev_y      = r_o_py;
    assign o_prev_w      = r_o_pw;
    assign o_visible     = r_o_vis;
    assign o_stripe_band = r_o_stripe;

`ifndef SYNTHESIS
    // The multiplier only runs for a segment in front of the camera.
    a_mul_needs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsp_pkg::S_MUL) |-> r_dpos)
        else $error("multiplier passes for a segment behind the camera");

    // A waiting result is never overwritten by the next one.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsp_pkg::S_OUT && r_out_valid && i_out_stall)
        |=> (r_state == rsp_pkg::S_OUT))
        else $error("result delivered over a stalled output");

    // A frame start restores the row limit to the full screen height.
    a_frame_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_frame_start) |=> (r_top == $signed({3'b000, r_hsh, 1'b0})))
        else $error("row limit not restored at frame start");
`endif

endmodule

// ===== src/rsp_divider.sv =====
// ----------------------------------------------------------------------------
// rsp_divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsp_divider (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [rsp_pkg::SCALE_FRAC_BITS-1:0]  i_num,
    input  logic [rsp_pkg::WORLD_W-1:0]          i_den,
    output logic                                 o_done,
    output logic [rsp_pkg::SCALE_FRAC_BITS-1:0]  o_quot
);

    localparam int QW = rsp_pkg::SCALE_FRAC_BITS;
    localparam int DW = rsp_pkg::WORLD_W;

    logic                           r_busy;
    logic                           r_done;
    logic [rsp_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [DW-1:0]                  r_rem;
    logic [DW-1:0]                  r_den;
    logic [QW-1:0]                  r_quo;

    logic [DW:0]                    trial;
    logic [DW+1:0]                  diff;
    logic                           ge;
    logic [DW-1:0]                  n_rem;
    logic [QW-1:0]                  n_quo;

    // One trial subtraction: shift in the next numerator bit.
    always_comb begin
        trial = {r_rem, r_quo[QW-1]};
        diff  = {1'b0, trial} - {2'b00, r_den};
        ge    = !diff[DW+1];
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_quo = {r_quo[QW-2:0], ge};
    end

    // The numerator shifts out of the quotient register as quotient bits enter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
                r_cnt  <= rsp_pkg::DIV_CNT_W'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - rsp_pkg::DIV_CNT_W'(1);
                if (r_cnt == rsp_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
